>>> sv/split_column_group_lookup_macros.svh
// Assertion macros for the split column group lookup block.
// Taken in by the top level; needs nothing else.
`ifndef SPLIT_COLUMN_GROUP_LOOKUP_MACROS_SVH
`define SPLIT_COLUMN_GROUP_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SCGL_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define SCGL_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

>>> sv/scgl_pkg.sv
// Shared constants, operation codes and control structs for the split column
// group lookup block. Depends on nothing.
package scgl_pkg;

   localparam int MAX_SPLITS = 64;
   localparam int INDEX_BITS = 16;
   localparam int COL_W      = 15;
   localparam int SIZE_W     = 7;
   localparam int ADDR_W     = (MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1;
   localparam int CNT_W      = $clog2(MAX_SPLITS + 1);

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   // Control from the sequencer to the compare and count unit
   typedef struct packed {
      logic             start;
      logic             sample;
      logic [COL_W-1:0] candidate;
   } scan_ctrl_type;

   // Running counts over one pass of the store
   typedef struct packed {
      logic [CNT_W-1:0] lt_count;
      logic [CNT_W-1:0] eq_count;
   } scan_stat_type;

endpackage

>>> sv/scgl_if.sv
// Request and response channel interfaces for the split column group lookup.
// Depends on scgl_pkg for field widths.
interface scgl_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           operation;
   logic signed [scgl_pkg::INDEX_BITS-1:0] split_value;
   logic [scgl_pkg::COL_W-1:0]           column_count;
   logic signed [scgl_pkg::INDEX_BITS-1:0] column_index;

   modport source (output valid, operation, split_value, column_count, column_index,
                   input ready);
   modport sink   (input valid, operation, split_value, column_count, column_index,
                   output ready);
endinterface

interface scgl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         group_found;
   logic [scgl_pkg::COL_W-1:0]   original_column;
   logic [scgl_pkg::COL_W-1:0]   group_start;
   logic [scgl_pkg::SIZE_W-1:0]  group_size;
   logic                         list_overflowed;

   modport source (output valid, group_found, original_column, group_start, group_size,
                   list_overflowed, input ready);
   modport sink   (input valid, group_found, original_column, group_start, group_size,
                   list_overflowed, output ready);
endinterface

>>> sv/split_column_group_lookup.sv
// Split column group lookup, one item at a time: clear and append are done in the
// idle state; a query with an index outside [0, count) goes straight to the result.
// Other queries binary-search S = ceil(log2(min(F, index) + 1)) steps, F = fill,
// each pass reading the store once through its single read port.
// Reset clears fill count, overflow flag and control; store contents stay undefined.
`include "split_column_group_lookup_macros.svh"

module split_column_group_lookup (
   input  logic              clock,
   input  logic              reset,
   scgl_req_if.sink          req_bus,
   scgl_rsp_if.source        rsp_bus
);

   localparam int CNT_W  = scgl_pkg::CNT_W;
   localparam int COL_W  = scgl_pkg::COL_W;
   localparam int SIZE_W = scgl_pkg::SIZE_W;
   localparam int ADDR_W = scgl_pkg::ADDR_W;
   localparam logic [CNT_W-1:0] FULL = CNT_W'(scgl_pkg::MAX_SPLITS);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PLAN = 5'b00010,
      ST_SCAN = 5'b00100,
      ST_EVAL = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic                       ovf_ff, ovf_in;
   logic [COL_W-1:0]           idx_ff, idx_in;
   logic [CNT_W-1:0]           lo_ff, lo_in;
   logic [CNT_W-1:0]           hi_ff, hi_in;
   logic [CNT_W-1:0]           mid_ff, mid_in;
   logic [COL_W-1:0]           cand_ff, cand_in;
   logic                       final_ff, final_in;
   logic [CNT_W-1:0]           scan_ff, scan_in;
   logic                       pend_ff, pend_in;
   logic                       res_found_ff, res_found_in;
   logic [COL_W-1:0]           res_orig_ff, res_orig_in;
   logic [COL_W-1:0]           res_start_ff, res_start_in;
   logic [SIZE_W-1:0]          res_size_ff, res_size_in;
   logic                       res_ovf_ff, res_ovf_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [COL_W-1:0]           rsp_orig_ff, rsp_orig_in;
   logic [COL_W-1:0]           rsp_start_ff, rsp_start_in;
   logic [SIZE_W-1:0]          rsp_size_ff, rsp_size_in;
   logic                       rsp_ovf_ff, rsp_ovf_in;

   logic                           ram_we;
   logic                           scan_rd;
   logic [scgl_pkg::INDEX_BITS-1:0] ram_rd_data;
   logic [CNT_W:0]                 mid_sum;
   logic [CNT_W:0]                 size_sum;
   logic                           rsp_free;
   logic [COL_W-1:0]               req_idx;
   scgl_pkg::scan_ctrl_type        ctrl;
   scgl_pkg::scan_stat_type        stat;

   // Split entry store
   scgl_ram #(
      .WIDTH (scgl_pkg::INDEX_BITS),
      .DEPTH (scgl_pkg::MAX_SPLITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (req_bus.split_value),
      .rd_en   (scan_rd),
      .rd_addr (scan_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Shared compare and count unit
   assign ctrl.start     = (state_ff == ST_PLAN);
   assign ctrl.sample    = pend_ff;
   assign ctrl.candidate = cand_ff;

   scgl_count_unit u_count (
      .clock (clock),
      .ctrl  (ctrl),
      .entry (ram_rd_data),
      .stat  (stat)
   );

   assign scan_rd  = (state_ff == ST_SCAN) && (scan_ff < fill_ff);
   assign mid_sum  = ({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1;
   assign size_sum = {1'b0, stat.eq_count} + (CNT_W + 1)'(1);
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_idx  = req_bus.column_index[COL_W-1:0];

   // Sequencer: the group's column is the largest o with o + entries below o
   // not above the index, found as index - j with j binary searched
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      cand_in      = cand_ff;
      final_in     = final_ff;
      scan_in      = scan_ff;
      pend_in      = scan_rd;
      res_found_in = res_found_ff;
      res_orig_in  = res_orig_ff;
      res_start_in = res_start_ff;
      res_size_in  = res_size_ff;
      res_ovf_in   = res_ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_orig_in  = rsp_orig_ff;
      rsp_start_in = rsp_start_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      ram_we       = 1'b0;

      // Drop the response once taken
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               case (scgl_pkg::op_type'(req_bus.operation))
                  scgl_pkg::OP_CLEAR: begin
                     fill_in = '0;
                     ovf_in  = 1'b0;
                  end
                  scgl_pkg::OP_APPEND: begin
                     if (fill_ff < FULL) begin
                        ram_we  = 1'b1;
                        fill_in = fill_ff + CNT_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  scgl_pkg::OP_QUERY: begin
                     res_ovf_in = ovf_ff;
                     if (req_bus.column_index[scgl_pkg::INDEX_BITS-1] ||
                         (req_idx >= req_bus.column_count)) begin
                        res_found_in = 1'b0;
                        res_orig_in  = '0;
                        res_start_in = '0;
                        res_size_in  = '0;
                        state_in     = ST_DONE;
                     end else begin
                        idx_in = req_idx;
                        lo_in  = '0;
                        if (COL_W'(fill_ff) <= req_idx) begin
                           hi_in = fill_ff;
                        end else begin
                           hi_in = CNT_W'(req_idx);
                        end
                        state_in = ST_PLAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_PLAN: begin
            // Pick the next probe, or the settled column for the last pass
            if (lo_ff < hi_ff) begin
               mid_in   = mid_sum[CNT_W-1:0];
               cand_in  = idx_ff - COL_W'(mid_sum[CNT_W-1:0]);
               final_in = 1'b0;
            end else begin
               cand_in  = idx_ff - COL_W'(lo_ff);
               final_in = 1'b1;
            end
            scan_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_rd) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (!scan_rd && !pend_ff) begin
               if (final_ff) begin
                  res_found_in = 1'b1;
                  res_orig_in  = cand_ff;
                  res_start_in = cand_ff + COL_W'(stat.lt_count);
                  res_size_in  = SIZE_W'(size_sum);
                  state_in     = ST_DONE;
               end else begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            // Probe fits when entries below it do not exceed the step back
            if (stat.lt_count <= mid_ff) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + CNT_W'(1);
            end
            state_in = ST_PLAN;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_orig_in  = res_orig_ff;
               rsp_start_in = res_start_ff;
               rsp_size_in  = res_size_ff;
               rsp_ovf_in   = res_ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      cand_ff      <= cand_in;
      final_ff     <= final_in;
      scan_ff      <= scan_in;
      res_found_ff <= res_found_in;
      res_orig_ff  <= res_orig_in;
      res_start_ff <= res_start_in;
      res_size_ff  <= res_size_in;
      res_ovf_ff   <= res_ovf_in;
      rsp_found_ff <= rsp_found_in;
      rsp_orig_ff  <= rsp_orig_in;
      rsp_start_ff <= rsp_start_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign req_bus.ready           = (state_ff == ST_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.group_found     = rsp_found_ff;
   assign rsp_bus.original_column = rsp_orig_ff;
   assign rsp_bus.group_start     = rsp_start_ff;
   assign rsp_bus.group_size      = rsp_size_ff;
   assign rsp_bus.list_overflowed = rsp_ovf_ff;

   // A negative query index goes straight to the result
   `SCGL_ASSERT_NEXT(neg_index_done, clock, reset, req_bus.valid && req_bus.ready && (req_bus.operation == scgl_pkg::OP_QUERY) && req_bus.column_index[scgl_pkg::INDEX_BITS-1], state_ff == ST_DONE)

   // A miss carries all-zero group fields
   `SCGL_ASSERT_NOW(miss_zero, clock, reset, rsp_valid_ff && !rsp_found_ff, (rsp_orig_ff == '0) && (rsp_start_ff == '0) && (rsp_size_ff == '0))

   // A hit starts at or after its original column and has a non-empty group
   `SCGL_ASSERT_NOW(hit_shape, clock, reset, rsp_valid_ff && rsp_found_ff, (rsp_start_ff >= rsp_orig_ff) && (rsp_size_ff != '0))

endmodule

>>> sv/scgl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module scgl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

>>> sv/scgl_count_unit.sv
// Shared compare and count unit: tests one stored entry a beat against the
// candidate column. Depends on scgl_pkg.
module scgl_count_unit (
   input  logic                           clock,
   input  scgl_pkg::scan_ctrl_type        ctrl,
   input  logic [scgl_pkg::INDEX_BITS-1:0] entry,
   output scgl_pkg::scan_stat_type        stat
);

   logic [scgl_pkg::INDEX_BITS-1:0] cand_ext;
   logic                            is_lt;
   logic                            is_eq;
   logic [scgl_pkg::CNT_W-1:0]      lt_ff, lt_in;
   logic [scgl_pkg::CNT_W-1:0]      eq_ff, eq_in;

   // Negative entries never count: their sign bit keeps them off both tests
   assign cand_ext = scgl_pkg::INDEX_BITS'(ctrl.candidate);
   assign is_lt    = !entry[scgl_pkg::INDEX_BITS-1] && (entry < cand_ext);
   assign is_eq    = (entry == cand_ext);

   // Clear at the start of a pass, accumulate on each returned entry
   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (ctrl.start) begin
         lt_in = '0;
         eq_in = '0;
      end else if (ctrl.sample) begin
         lt_in = lt_ff + scgl_pkg::CNT_W'(is_lt);
         eq_in = eq_ff + scgl_pkg::CNT_W'(is_eq);
      end
   end

   always_ff @(posedge clock) begin
      lt_ff <= lt_in;
      eq_ff <= eq_in;
   end

   assign stat.lt_count = lt_ff;
   assign stat.eq_count = eq_ff;

endmodule
